>>> hdl/koes_pkg.sv
`timescale 1ns / 1ps
package koes_pkg;
    localparam int FRAC_BITS_DEF = 20;
    localparam int ADDR_W = 5;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [20:0] STEP_MAX = 21'h1F_FFFF;
    localparam logic [63:0] GM_Q32 = 64'd169558512509;
    localparam logic [33:0] ACC_CAP = 34'h2_0000_0000;

    typedef enum logic [2:0] {
        REG_STEP   = 3'd0,
        REG_START_X  = 3'd1,
        REG_START_Y  = 3'd2,
        REG_START_VX = 3'd3,
        REG_START_VY = 3'd4
    } t_reg_idx;

    // start request / result of the shared divide/sqrt unit
    typedef struct packed {
        logic         start;
        logic         is_sqrt;
        logic [127:0] num;
        logic [127:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic        big;
    } t_div_rsp;

    function automatic logic [31:0] clip32(input logic signed [65:0] v, output logic f);
        f = 1'b0;
        if (v > 66'sd2147483647) begin
            f = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -66'sd2147483648) begin
            f = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction
endpackage

>>> hdl/kepler_orbit_euler_step_core.sv
`timescale 1ns / 1ps
// semi-implicit euler two-body orbit stepper, signed Q(32-F).F state
// input channel: i_valid/o_ready with i_restart; one beat per step request
// output channel: o_valid/i_ready carrying the new position, velocity,
// elapsed time and the saturated / singular flags, one result beat per input
// a restart beat loads the state from the start registers and clears the
// time, result valid in the cycle after acceptance; a step beat runs one
// 32-step square root and two 128-step divisions on the one shared
// bit-serial unit (skipped when r^2 is zero), wide products on a 32x32
// multiplier built low half then high half, and four update states
// o_ready is low from acceptance until the result beat is taken, so a
// stalled receiver holds the block with the result steady on the outputs
// configuration goes through the apb port (registers at 4*i) while idle;
// the block does not enforce this, the user keeps to it
// reset (synchronous, active low) loads the default start state: x = 5 au,
// vy for a circular orbit, time zero, step 0.01 year
module kepler_orbit_euler_step_core #(
    parameter int FRAC_BITS = koes_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_pos_x_out,
    output logic [31:0] o_pos_y_out,
    output logic [31:0] o_vel_x_out,
    output logic [31:0] o_vel_y_out,
    output logic [47:0] o_time_out,
    output logic        o_saturated,
    output logic        o_singular,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [koes_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [63:0] STEP_SH = (FRAC_BITS >= 20) ?
        (64'(10486) << (FRAC_BITS - 20)) : (64'(10486) >> (20 - FRAC_BITS));
    localparam logic [20:0] STEP_RST = (STEP_SH > 64'(koes_pkg::STEP_MAX)) ?
        koes_pkg::STEP_MAX : STEP_SH[20:0];
    localparam logic [31:0] VY_RST = (FRAC_BITS >= 20) ?
        32'(64'(2946418) << (FRAC_BITS - 20)) : 32'(64'(2946418) >> (20 - FRAC_BITS));
    localparam logic [31:0] X_RST = 32'(64'(5) << FRAC_BITS);
    localparam int SH = 3 * FRAC_BITS - 32;
    localparam logic [31:0] GM_LO = 32'(koes_pkg::GM_Q32);
    localparam logic [31:0] GM_HI = 32'(koes_pkg::GM_Q32 >> 32);

    typedef enum logic [3:0] {
        S_IDLE, S_R2, S_SQRT, S_DEN, S_DENH, S_NUMX, S_NUMXH, S_DIVX,
        S_NUMY, S_NUMYH, S_DIVY, S_VX, S_PX, S_VY, S_PY, S_OUT
    } t_state;

    t_state r_state;
    logic [20:0] r_step;
    logic [31:0] r_sx, r_sy, r_svx, r_svy;
    logic signed [31:0] r_px, r_py, r_vx, r_vy, r_ax, r_ay;
    logic [47:0] r_time;
    logic [63:0] r_r2, r_root;
    logic [127:0] r_den, r_num;
    logic r_sat, r_sing, r_valid, r_ready, r_go, r_issqrt;

    koes_pkg::t_div_req w_req;
    koes_pkg::t_div_rsp w_rsp;

    koes_div_unit u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign w_req.start   = r_go;
    assign w_req.is_sqrt = r_issqrt;
    assign w_req.num     = r_issqrt ? {r_r2, 64'd0} : r_num;
    assign w_req.den     = r_den;

    // shared 32x32 multiplier, wide products built low half then high half
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic [31:0] w_xa, w_ya;
    assign w_xa = r_px[31] ? 32'(-r_px) : r_px;
    assign w_ya = r_py[31] ? 32'(-r_py) : r_py;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_R2:    begin w_ma = w_xa; w_mb = w_xa; end
            S_SQRT:  begin w_ma = w_ya; w_mb = w_ya; end
            S_DEN:   begin w_ma = r_r2[31:0]; w_mb = r_root[31:0]; end
            S_DENH:  begin w_ma = r_r2[63:32]; w_mb = r_root[31:0]; end
            S_NUMX:  begin w_ma = GM_LO; w_mb = w_xa; end
            S_NUMXH: begin w_ma = GM_HI; w_mb = w_xa; end
            S_NUMY:  begin w_ma = GM_LO; w_mb = w_ya; end
            S_NUMYH: begin w_ma = GM_HI; w_mb = w_ya; end
            default: ;
        endcase
        w_prod = {32'd0, w_ma} * {32'd0, w_mb};
    end

    // velocity / position update datapath
    logic signed [31:0] w_fa, w_fb;
    logic signed [53:0] w_p;
    logic signed [53:0] w_fl;
    logic signed [65:0] w_sum;
    logic [31:0] w_clip;
    logic w_cf;
    always_comb begin
        unique case (r_state)
            S_VX:    begin w_fa = r_ax; w_fb = r_vx; end
            S_PX:    begin w_fa = r_vx; w_fb = r_px; end
            S_VY:    begin w_fa = r_ay; w_fb = r_vy; end
            default: begin w_fa = r_vy; w_fb = r_py; end
        endcase
        w_p   = 54'(w_fa) * $signed({33'd0, r_step});
        w_fl  = w_p >>> FRAC_BITS;
        w_sum = 66'(w_fb) + 66'(w_fl);
        w_clip = koes_pkg::clip32(w_sum, w_cf);
    end

    // acceleration from quotient
    logic [31:0] w_acc;
    logic w_af;
    logic signed [65:0] w_q;
    logic w_neg;
    assign w_neg = (r_state == S_DIVX) ? r_px[31] : r_py[31];
    always_comb begin
        w_q = w_rsp.big ? 66'(koes_pkg::ACC_CAP) : 66'(w_rsp.quo[33:0]);
        if (!w_neg) w_q = -w_q;
        w_acc = koes_pkg::clip32(w_q, w_af);
    end

    logic [48:0] w_tsum;
    assign w_tsum = {1'b0, r_time} + 49'(r_step);

    wire w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= STEP_RST;
            r_sx <= X_RST; r_sy <= '0; r_svx <= '0; r_svy <= VY_RST;
            r_px <= X_RST; r_py <= '0; r_vx <= '0; r_vy <= VY_RST;
            r_time <= '0;
            r_root <= '0;
            r_valid <= 1'b0;
            r_ready <= 1'b1;
            r_go <= 1'b0;
            r_issqrt <= 1'b0;
            r_sat <= 1'b0;
            r_sing <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (w_wr) begin
                unique case (paddr[koes_pkg::ADDR_W-1:2])
                    3'(koes_pkg::REG_STEP):     r_step <= pwdata[20:0];
                    3'(koes_pkg::REG_START_X):  r_sx <= pwdata;
                    3'(koes_pkg::REG_START_Y):  r_sy <= pwdata;
                    3'(koes_pkg::REG_START_VX): r_svx <= pwdata;
                    3'(koes_pkg::REG_START_VY): r_svy <= pwdata;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (i_valid && r_ready) begin
                    r_ready <= 1'b0;
                    r_sat <= 1'b0;
                    r_sing <= 1'b0;
                    if (i_restart) begin
                        r_px <= r_sx; r_py <= r_sy; r_vx <= r_svx; r_vy <= r_svy;
                        r_time <= '0;
                        r_state <= S_OUT;
                        r_valid <= 1'b1;
                    end else begin
                        r_state <= S_R2;
                    end
                end
                S_R2: begin
                    r_r2 <= w_prod;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    // add y^2 then launch sqrt once
                    if (!r_issqrt) begin
                        r_r2 <= r_r2 + w_prod;
                        r_issqrt <= 1'b1;
                    end else if (r_r2 == 64'd0) begin
                        r_issqrt <= 1'b0;
                        r_sing <= 1'b1;
                        r_ax <= '0; r_ay <= '0;
                        r_state <= S_VX;
                    end else if (!r_go && w_rsp.done) begin
                        r_issqrt <= 1'b0;
                        r_root <= w_rsp.quo;
                        r_state <= S_DEN;
                    end else if (r_issqrt && !r_go && r_root != 64'hFFFF_FFFF_FFFF_FFFF) begin
                        r_go <= 1'b1;
                        r_root <= 64'hFFFF_FFFF_FFFF_FFFF;
                    end
                end
                S_DEN: begin
                    r_den <= {64'd0, w_prod};
                    r_state <= S_DENH;
                end
                S_DENH: begin
                    r_den <= r_den + {32'd0, w_prod, 32'd0};
                    r_state <= S_NUMX;
                end
                S_NUMX: begin
                    r_num <= {64'd0, w_prod};
                    r_state <= S_NUMXH;
                end
                S_NUMXH: begin
                    r_num <= (r_num + {32'd0, w_prod, 32'd0}) << SH;
                    r_go <= 1'b1;
                    r_state <= S_DIVX;
                end
                S_DIVX: if (w_rsp.done) begin
                    r_ax <= w_acc;
                    if (w_af) r_sat <= 1'b1;
                    r_state <= S_NUMY;
                end
                S_NUMY: begin
                    r_num <= {64'd0, w_prod};
                    r_state <= S_NUMYH;
                end
                S_NUMYH: begin
                    r_num <= (r_num + {32'd0, w_prod, 32'd0}) << SH;
                    r_go <= 1'b1;
                    r_state <= S_DIVY;
                end
                S_DIVY: if (w_rsp.done) begin
                    r_ay <= w_acc;
                    if (w_af) r_sat <= 1'b1;
                    r_state <= S_VX;
                end
                S_VX: begin
                    r_vx <= w_clip; if (w_cf) r_sat <= 1'b1; r_state <= S_PX;
                end
                S_PX: begin
                    r_px <= w_clip; if (w_cf) r_sat <= 1'b1; r_state <= S_VY;
                end
                S_VY: begin
                    r_vy <= w_clip; if (w_cf) r_sat <= 1'b1; r_state <= S_PY;
                end
                S_PY: begin
                    r_py <= w_clip; if (w_cf) r_sat <= 1'b1;
                    if (w_tsum > {1'b0, koes_pkg::TIME_MAX}) begin
                        r_time <= koes_pkg::TIME_MAX;
                        r_sat <= 1'b1;
                    end else begin
                        r_time <= w_tsum[47:0];
                    end
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) begin
                    r_valid <= 1'b0;
                    r_ready <= 1'b1;
                    r_root <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[koes_pkg::ADDR_W-1:2])
            3'(koes_pkg::REG_STEP):     prdata = {11'd0, r_step};
            3'(koes_pkg::REG_START_X):  prdata = r_sx;
            3'(koes_pkg::REG_START_Y):  prdata = r_sy;
            3'(koes_pkg::REG_START_VX): prdata = r_svx;
            3'(koes_pkg::REG_START_VY): prdata = r_svy;
            default:                    prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_ready = r_ready;
    assign o_valid = r_valid;
    assign o_pos_x_out = r_px;
    assign o_pos_y_out = r_py;
    assign o_vel_x_out = r_vx;
    assign o_vel_y_out = r_vy;
    assign o_time_out = r_time;
    assign o_saturated = r_sat;
    assign o_singular = r_sing;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pos_x_out) && $stable(o_time_out))
        else $error("result changed under stall");
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> o_ready && !o_valid) else $error("no return to idle");
endmodule

>>> hdl/koes_div_unit.sv
`timescale 1ns / 1ps
// bit-serial restoring divider and integer square root, one bit per cycle while busy
module koes_div_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  koes_pkg::t_div_req  i_req,
    output koes_pkg::t_div_rsp  o_rsp
);
    logic [127:0] r_num;
    logic [127:0] r_den;
    logic [128:0] r_rem;
    logic [63:0]  r_quo;
    logic         r_big;
    logic [6:0]   r_cnt;
    logic         r_busy;
    logic         r_sqrt;
    logic         r_done;
    logic [128:0] n_rem;
    logic [128:0] n_trial;
    logic         n_ge;
    logic [63:0]  n_res;

    always_comb begin
        if (r_sqrt) begin
            // restoring sqrt: two bits of radicand per step
            n_rem   = {r_rem[126:0], r_num[127:126]};
            n_trial = {63'd0, r_quo, 2'b01};
            n_res   = {r_quo[62:0], 1'b0};
        end else begin
            n_rem   = {r_rem[127:0], r_num[127]};
            n_trial = {1'b0, r_den};
            n_res   = {r_quo[62:0], 1'b0};
        end
        n_ge = n_rem >= n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.is_sqrt;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_big  <= 1'b0;
                // sqrt radicand sits in the upper 64 bits: 32 steps
                r_cnt  <= i_req.is_sqrt ? 7'd31 : 7'd127;
            end else if (r_busy) begin
                r_num <= r_sqrt ? {r_num[125:0], 2'b00} : {r_num[126:0], 1'b0};
                if (n_ge) begin
                    r_rem <= n_rem - n_trial;
                    if (!r_sqrt && r_cnt >= 7'd33)
                        r_big <= 1'b1;
                    r_quo <= n_res | 64'd1;
                end else begin
                    r_rem <= n_rem;
                    r_quo <= n_res;
                end
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 7'd1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.big  = r_big;
endmodule

>>> verif/orbit_step_checker.sv
`timescale 1ns / 1ps
module orbit_step_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic        i_restart,
    input  logic        i_out_valid,
    input  logic        i_ready,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [47:0] i_time,
    input  logic        i_saturated,
    input  logic        i_singular,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [koes_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int F = koes_pkg::FRAC_BITS_DEF;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [47:0] elapsed;
        logic        sat;
        logic        sing;
    } t_orbit_beat;

    t_orbit_beat expected_beats[$];

    logic [20:0]        step_size;
    logic [31:0]        start_x, start_y, start_vx, start_vy;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic [47:0]        elapsed;
    int                 fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_beats.size();

    function automatic logic signed [31:0] clip_q(input logic signed [65:0] v,
                                                  inout logic flag);
        if (v > 66'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -66'sd2147483648) begin
            flag = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // pull toward the origin, quotient capped at 2^33 before clipping
    function automatic logic signed [31:0] gravity(input logic signed [31:0] p,
                                                   input logic [127:0] den,
                                                   inout logic flag);
        logic signed [63:0] sp;
        logic [127:0]       mag, num, q;
        logic signed [65:0] v;
        sp  = p;
        mag = sp < 0 ? 128'(-sp) : 128'(sp);
        num = (128'(koes_pkg::GM_Q32) * mag) << (3 * F - 32);
        q   = num / den;
        if (q >= 128'(koes_pkg::ACC_CAP)) q = 128'(koes_pkg::ACC_CAP);
        v = p < 0 ? $signed({32'b0, q[33:0]}) : -$signed({32'b0, q[33:0]});
        return clip_q(v, flag);
    endfunction

    function automatic t_orbit_beat advance_orbit(input logic restart);
        t_orbit_beat        b;
        logic signed [63:0] sx, sy, dt, prod;
        logic [63:0]        r2;
        logic [127:0]       den;
        logic signed [31:0] ax, ay;
        logic [48:0]        tsum;
        logic               sat, sing;
        sat = 0;
        sing = 0;
        if (restart) begin
            pos_x = start_x;
            pos_y = start_y;
            vel_x = start_vx;
            vel_y = start_vy;
            elapsed = 0;
        end else begin
            sx = pos_x;
            sy = pos_y;
            r2 = 64'(sx * sx) + 64'(sy * sy);
            dt = {43'b0, step_size};
            ax = 0;
            ay = 0;
            if (r2 == 0) begin
                sing = 1;
            end else begin
                den = 128'(r2) * 128'(floor_sqrt(r2));
                ax = gravity(pos_x, den, sat);
                ay = gravity(pos_y, den, sat);
            end
            prod  = ax * dt;
            vel_x = clip_q($signed(66'(vel_x)) + $signed(66'(prod >>> F)), sat);
            prod  = vel_x * dt;
            pos_x = clip_q($signed(66'(pos_x)) + $signed(66'(prod >>> F)), sat);
            prod  = ay * dt;
            vel_y = clip_q($signed(66'(vel_y)) + $signed(66'(prod >>> F)), sat);
            prod  = vel_y * dt;
            pos_y = clip_q($signed(66'(pos_y)) + $signed(66'(prod >>> F)), sat);
            tsum = {1'b0, elapsed} + 49'(step_size);
            if (tsum > 49'(koes_pkg::TIME_MAX)) begin
                elapsed = koes_pkg::TIME_MAX;
                sat = 1;
            end else begin
                elapsed = tsum[47:0];
            end
        end
        b.pos_x = pos_x;
        b.pos_y = pos_y;
        b.vel_x = vel_x;
        b.vel_y = vel_y;
        b.elapsed = elapsed;
        b.sat = sat;
        b.sing = sing;
        return b;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_orbit_beat e;
        if (!i_rst_n) begin
            step_size <= 21'(10486);
            start_x   <= 32'(5 << F);
            start_y   <= 0;
            start_vx  <= 0;
            start_vy  <= 32'd2946418;
            pos_x     <= 32'(5 << F);
            pos_y     <= 0;
            vel_x     <= 0;
            vel_y     <= 32'd2946418;
            elapsed   <= 0;
            fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite) begin
                case (koes_pkg::t_reg_idx'(i_paddr[koes_pkg::ADDR_W-1:2]))
                    koes_pkg::REG_STEP:     step_size = i_pwdata[20:0];
                    koes_pkg::REG_START_X:  start_x = i_pwdata;
                    koes_pkg::REG_START_Y:  start_y = i_pwdata;
                    koes_pkg::REG_START_VX: start_vx = i_pwdata;
                    koes_pkg::REG_START_VY: start_vy = i_pwdata;
                    default: ;
                endcase
            end
            if (i_valid && i_in_ready) expected_beats.push_back(advance_orbit(i_restart));
            if (i_out_valid && i_ready) begin
                if (expected_beats.size() == 0) begin
                    report("unexpected beat", 0, 0);
                end else begin
                    e = expected_beats.pop_front();
                    if (i_pos_x != e.pos_x) report("pos_x", i_pos_x, e.pos_x);
                    if (i_pos_y != e.pos_y) report("pos_y", i_pos_y, e.pos_y);
                    if (i_vel_x != e.vel_x) report("vel_x", i_vel_x, e.vel_x);
                    if (i_vel_y != e.vel_y) report("vel_y", i_vel_y, e.vel_y);
                    if (i_time != e.elapsed) report("time", i_time, e.elapsed);
                    if (i_saturated != e.sat) report("saturated", i_saturated, e.sat);
                    if (i_singular != e.sing) report("singular", i_singular, e.sing);
                end
            end
        end
    end
endmodule

>>> verif/kepler_orbit_euler_step_core_test.sv
`timescale 1ns / 1ps
module kepler_orbit_euler_step_core_test;
    localparam int IDLE_LIMIT = 20000;
    // index with no register behind it
    localparam koes_pkg::t_reg_idx REG_UNUSED = koes_pkg::t_reg_idx'(3'd6);

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready, i_restart, o_valid, i_ready;
    logic [31:0] o_pos_x_out, o_pos_y_out, o_vel_x_out, o_vel_y_out;
    logic [47:0] o_time_out;
    logic        o_saturated, o_singular;
    logic        psel, penable, pwrite, pready;
    logic [koes_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending, burst_left;
    int          idle_cycles = 0;
    int          mode = 0;
    int          mode_left = 0;

    kepler_orbit_euler_step_core u_top (.*);

    orbit_step_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_ready(o_ready),
        .i_restart(i_restart), .i_out_valid(o_valid), .i_ready(i_ready),
        .i_pos_x(o_pos_x_out), .i_pos_y(o_pos_y_out), .i_vel_x(o_vel_x_out),
        .i_vel_y(o_vel_y_out), .i_time(o_time_out), .i_saturated(o_saturated),
        .i_singular(o_singular), .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stalls: modes of never, light and heavy stalling
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(50, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        i_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) >= mode);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic reg_write(input koes_pkg::t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= koes_pkg::ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
    endtask

    // drop valid after the last beat, then wait until nothing is in flight
    task automatic wait_idle();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic send_beat(input logic restart);
        logic hs;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                i_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1;
        i_restart <= restart;
        forever begin
            @(negedge i_clk);
            hs = o_ready;
            @(posedge i_clk);
            if (hs) break;
        end
    endtask

    task automatic load_start(input logic [31:0] x, y, vx, vy);
        reg_write(koes_pkg::REG_START_X, x);
        reg_write(koes_pkg::REG_START_Y, y);
        reg_write(koes_pkg::REG_START_VX, vx);
        reg_write(koes_pkg::REG_START_VY, vy);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 3);
            3: return $urandom;
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23)) << 2;
        endcase
    endfunction

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_restart = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        burst_left = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // default circular orbit, then a restart mid-run
        repeat (3) send_beat(0);
        send_beat(1);
        send_beat(0);
        wait_idle();
        // sun at the planet: a singular first step that still drifts
        load_start(0, 0, 32'h0010_0000, 32'hFFF0_0000);
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_beat(1);
        repeat (2) send_beat(0);
        wait_idle();
        // corners and tiny radius with step extremes
        load_start(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        reg_write(koes_pkg::REG_STEP, 32'h001F_FFFF);
        send_beat(1);
        repeat (2) send_beat(0);
        wait_idle();
        load_start(1, 0, 0, 0);
        reg_write(koes_pkg::REG_STEP, 1);
        send_beat(1);
        repeat (2) send_beat(0);
        wait_idle();
        reg_write(koes_pkg::REG_STEP, 0);
        load_start(32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF);
        send_beat(1);
        repeat (2) send_beat(0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            reg_write(koes_pkg::REG_STEP, ph == 0 ? 32'h001F_FFFF : ph == 1 ? 1 :
                      ($urandom_range(0, 1) ? $urandom_range(1, 20000) : $urandom));
            if (ph < 4)
                load_start(32'($urandom_range(1 << 20, 8 << 20)),
                           32'($signed($urandom_range(0, 8 << 20)) - (4 << 20)),
                           32'($signed($urandom_range(0, 4 << 20)) - (2 << 20)),
                           32'($urandom_range(0, 6 << 20)));
            else
                load_start(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            send_beat(1);
            for (int n = 0; n < 120; n++) send_beat($urandom_range(0, 15) == 0);
            wait_idle();
        end

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
